// ===== sv/bsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg: shared types, constants and signature tables
// Types, byte window geometry, header and footer signature tables and the
// match functions used by the signature carver.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // block geometry
  localparam int unsigned BLOCK_BYTES  = 1024;
  localparam int unsigned POS_W        = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned WIN_BYTES    = 10;
  localparam int unsigned BLK_W        = 32;
  localparam int unsigned SPAN_W       = 12;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 12'd12;

  // register map: index is paddr[2]
  localparam logic ADDR_MAX_SPAN = 1'b0;

  // signature table sizes
  localparam int unsigned HEAD_ENTRIES = 7;
  localparam int unsigned HEAD_MAX     = 8;
  localparam int unsigned FOOT_ENTRIES = 6;
  localparam int unsigned FOOT_MAX     = 10;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] code_t;   // 0 none, else 1 + file kind
  typedef logic [2:0] kind_t;
  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [WIN_BYTES-1:0][7:0] win_t;

  typedef struct packed {
    logic  valid;
    byte_t data;
  } cell_t;

  typedef enum logic [2:0] {
    VERDICT_NONE     = 3'd0,
    VERDICT_REPEAT   = 3'd1,
    VERDICT_OPEN     = 3'd2,
    VERDICT_MISMATCH = 3'd3,
    VERDICT_RECOVER  = 3'd4,
    VERDICT_SPAN     = 3'd5
  } verdict_t;

  localparam kind_t KIND_GIF = 3'd0;
  localparam kind_t KIND_PNG = 3'd1;
  localparam kind_t KIND_JPG = 3'd2;
  localparam kind_t KIND_PDF = 3'd3;
  localparam kind_t KIND_CPP = 3'd4;
  localparam kind_t KIND_PHP = 3'd5;

  // header signatures, first hit wins
  localparam byte_t HEAD_PAT [HEAD_ENTRIES][HEAD_MAX] = '{
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
    '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h31, 8'h2E, 8'h00},
    '{8'h23, 8'h69, 8'h6E, 8'h63, 8'h6C, 8'h75, 8'h64, 8'h65},
    '{8'h3C, 8'h3F, 8'h70, 8'h68, 8'h70, 8'h3E, 8'h00, 8'h00}
  };
  localparam int unsigned HEAD_LEN [HEAD_ENTRIES] = '{4, 8, 4, 4, 7, 8, 6};
  localparam kind_t HEAD_KIND [HEAD_ENTRIES] = '{
    KIND_GIF, KIND_PNG, KIND_JPG, KIND_JPG, KIND_PDF, KIND_CPP, KIND_PHP
  };

  // footer signatures, entry e is kind e
  localparam byte_t FOOT_PAT [FOOT_ENTRIES][FOOT_MAX] = '{
    '{8'h00, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h49, 8'h45, 8'h4E, 8'h44, 8'hAE, 8'h42, 8'h60, 8'h82},
    '{8'hFF, 8'hD9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h25, 8'h45, 8'h4F, 8'h46, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3C, 8'h2F, 8'h70, 8'h68, 8'h70, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int unsigned FOOT_LEN [FOOT_ENTRIES] = '{2, 10, 2, 6, 6, 6};

  // header code at a window offset; pattern must end inside the window
  function automatic code_t head_match(input win_t win, input int unsigned base);
    code_t code;
    logic  hit;
    int    e;
    int    k;
    code = '0;
    for (e = HEAD_ENTRIES - 1; e >= 0; e--) begin
      hit = (base + HEAD_LEN[e] <= WIN_BYTES);
      for (k = 0; k < HEAD_MAX; k++) begin
        if (k < HEAD_LEN[e] && base + k < WIN_BYTES) begin
          if (win[base + k] != HEAD_PAT[e][k]) hit = 1'b0;
        end
      end
      if (hit) code = HEAD_KIND[e] + 3'd1;
    end
    return code;
  endfunction

  // footer code at a window offset; pattern must end inside the window
  function automatic code_t foot_match(input win_t win, input int unsigned base);
    code_t code;
    logic  hit;
    int    e;
    int    k;
    code = '0;
    for (e = FOOT_ENTRIES - 1; e >= 0; e--) begin
      hit = (base + FOOT_LEN[e] <= WIN_BYTES);
      for (k = 0; k < FOOT_MAX; k++) begin
        if (k < FOOT_LEN[e] && base + k < WIN_BYTES) begin
          if (win[base + k] != FOOT_PAT[e][k]) hit = 1'b0;
        end
      end
      if (hit) code = code_t'(e + 1);
    end
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bsc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_cell: one byte cell of the window chain
// Holds one byte and a flag saying it belongs to the current block; takes its
// neighbor's byte on every shift. A flush drops the flag of the byte taken.
// ----------------------------------------------------------------------------
module bsc_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  logic           flush,
  input  bsc_pkg::cell_t feed,
  output bsc_pkg::cell_t held,
  output bsc_pkg::cell_t nxt
);
  import bsc_pkg::*;

  logic  valid;
  byte_t data;

  assign held = '{valid: valid, data: data};

  // next content of the cell
  always_comb begin
    nxt = held;
    if (shift) begin
      nxt.data  = feed.data;
      nxt.valid = feed.valid && !flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    data <= nxt.data;
  end

endmodule
`default_nettype wire

// ===== sv/bsc_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_match: signature comparator bank
// Compares the byte window against every header and footer signature at
// every window offset at once.
// ----------------------------------------------------------------------------
module bsc_match (
  input  bsc_pkg::win_t                                 win,
  output logic [bsc_pkg::WIN_BYTES-1:0][2:0]            head_code,
  output logic [bsc_pkg::WIN_BYTES-1:0][2:0]            foot_code
);
  import bsc_pkg::*;

  // one comparator set per offset
  for (genvar b = 0; b < WIN_BYTES; b++) begin : g_base
    assign head_code[b] = head_match(win, b);
    assign foot_code[b] = foot_match(win, b);
  end

endmodule
`default_nettype wire

// ===== sv/block_signature_carver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// block_signature_carver: header/footer signature scan over storage blocks
// Streams block bytes through a ten-cell window, finds magic headers at the
// block start and the first footer, and gives one verdict per block.
// ----------------------------------------------------------------------------
// Takes one byte per cycle; a block ends at the beat flagged last_byte, and
// its verdict beat appears in the output register on the next cycle. Bytes
// keep streaming without a gap as long as out_ready drains each verdict; while
// a verdict beat waits with out_ready low, in_ready is low and no byte is
// taken. The byte
// window is a row of ten cells shifting once per byte, with a comparator bank
// that checks every signature at every offset in the same cycle. Bytes past
// BLOCK_BYTES in one block are ignored. max_span sits at byte address 0.
module block_signature_carver (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [31:0] block_number,
  input  logic        last_byte,
  // verdict output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [2:0]  file_kind,
  output logic [31:0] start_block,
  output logic [31:0] end_block,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsc_pkg::*;

  // config register
  logic [SPAN_W-1:0] max_span;

  // block tracking
  logic [POS_W-1:0] pos;
  blk_t             cur_block;
  code_t            header_code;
  code_t            footer_code;

  // search state
  logic  search_open;
  kind_t open_kind;
  blk_t  header_block;
  blk_t  prev_block;
  logic  prev_valid;

  logic  search_open_next;
  kind_t open_kind_next;
  blk_t  header_block_next;

  // handshake and window
  logic accept;
  logic shift;
  logic flush;
  logic finish;
  cell_t [WIN_BYTES-1:0] held;
  cell_t [WIN_BYTES-1:0] nxt;
  cell_t [WIN_BYTES-1:0] feed;
  win_t                  win_next;
  logic [WIN_BYTES-1:0]  valid_next;
  logic [WIN_BYTES-1:0][2:0] head_code;
  logic [WIN_BYTES-1:0][2:0] foot_code;

  code_t hdr_now;
  code_t hdr;
  code_t foot;
  blk_t  cur;
  logic  gap;
  logic  repeat_hdr;

  verdict_t v_res;
  kind_t    k_res;
  blk_t     s_res;
  blk_t     e_res;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_MAX_SPAN) ? {{(32 - SPAN_W){1'b0}}, max_span} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_span <= SPAN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_MAX_SPAN) begin
      max_span <= pwdata[SPAN_W-1:0];
    end
  end

  // handshake
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign shift    = accept && (pos < POS_W'(BLOCK_BYTES));
  assign flush    = (pos == '0);
  assign finish   = accept && last_byte;

  // window chain: new byte enters the top cell
  for (genvar i = 0; i < WIN_BYTES; i++) begin : g_cell
    if (i == WIN_BYTES - 1) begin : g_top
      assign feed[i] = '{valid: 1'b1, data: data_byte};
      bsc_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .flush(1'b0),
        .feed (feed[i]),
        .held (held[i]),
        .nxt  (nxt[i])
      );
    end else begin : g_mid
      assign feed[i] = held[i+1];
      bsc_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .flush(flush),
        .feed (feed[i]),
        .held (held[i]),
        .nxt  (nxt[i])
      );
    end
    assign win_next[i]   = nxt[i].data;
    assign valid_next[i] = nxt[i].valid;
  end

  bsc_match u_match (
    .win      (win_next),
    .head_code(head_code),
    .foot_code(foot_code)
  );

  // header at the first byte of the block (first valid cell, offset 2 or up)
  always_comb begin
    hdr_now = '0;
    for (int b = 2; b < WIN_BYTES; b++) begin
      if (valid_next[b] && !valid_next[b-1]) hdr_now = hdr_now | head_code[b];
    end
  end

  // stored code once the block holds nine or more bytes
  assign hdr = valid_next[1] ? header_code : hdr_now;

  // first footer: streamed result, else lowest offset left in the window
  always_comb begin
    foot = '0;
    for (int b = WIN_BYTES - 1; b >= 0; b--) begin
      if (valid_next[b] && foot_code[b] != '0) foot = foot_code[b];
    end
    if (footer_code != '0) foot = footer_code;
  end

  assign cur = flush ? block_number : cur_block;

  // block-end decision
  always_comb begin
    gap               = !prev_valid || (cur - prev_block != 32'd1);
    search_open_next  = search_open && !gap;
    open_kind_next    = open_kind;
    header_block_next = header_block;
    repeat_hdr        = 1'b0;
    v_res             = VERDICT_NONE;
    k_res             = '0;
    s_res             = '0;
    e_res             = '0;
    if (hdr != '0) begin
      if (!search_open_next) begin
        search_open_next  = 1'b1;
        open_kind_next    = hdr - 3'd1;
        header_block_next = cur;
      end else begin
        v_res            = VERDICT_REPEAT;
        k_res            = open_kind;
        s_res            = header_block;
        search_open_next = 1'b0;
        repeat_hdr       = 1'b1;
      end
    end
    if (!repeat_hdr && search_open_next) begin
      k_res = open_kind_next;
      s_res = header_block_next;
      if (foot != '0) begin
        if (foot - 3'd1 == open_kind_next) begin
          v_res = VERDICT_RECOVER;
          e_res = cur;
        end else begin
          v_res = VERDICT_MISMATCH;
        end
        search_open_next = 1'b0;
      end else if (cur - header_block_next >= {{(BLK_W - SPAN_W){1'b0}}, max_span}) begin
        v_res            = VERDICT_SPAN;
        search_open_next = 1'b0;
      end else begin
        v_res = VERDICT_OPEN;
      end
    end
  end

  // block tracking registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      header_code <= '0;
      footer_code <= '0;
    end else if (finish) begin
      pos         <= '0;
      header_code <= '0;
      footer_code <= '0;
    end else if (shift) begin
      pos <= pos + 1'b1;
      if (valid_next[2] && !valid_next[1]) header_code <= hdr_now;
      if (footer_code == '0 && valid_next[0]) footer_code <= foot_code[0];
    end
  end

  always_ff @(posedge clk) begin
    if (shift && flush) cur_block <= block_number;
  end

  // search state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_open <= 1'b0;
      prev_valid  <= 1'b0;
    end else if (finish) begin
      search_open <= search_open_next;
      prev_valid  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      open_kind    <= open_kind_next;
      header_block <= header_block_next;
      prev_block   <= cur;
    end
  end

  // verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      verdict     <= v_res;
      file_kind   <= k_res;
      start_block <= s_res;
      end_block   <= e_res;
    end
  end

endmodule
`default_nettype wire
